### src/isi_pkg.sv
// Shared types and constants for the integer insertion sorter.
`timescale 1ns / 1ps

package isi_pkg;

    localparam int DATA_W = 32;

    // One input transfer: an element and the end-of-set marker
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    // One result transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     dropped;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // latch the accepted item, fetch the top stored entry
        logic set_ovf;    // record a dropped element
        logic shift;      // move the fetched entry up one place
        logic place;      // write the new element at the current position
        logic start_out;  // fetch entry zero for the output run
        logic load_out;   // load the output register, fetch the next entry
        logic clear;      // empty the store for the next set
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;       // store holds its maximum number of entries
        logic fill_zero;  // store is empty
        logic greater;    // fetched entry is greater than the new element
        logic pos_one;    // insertion position is one
        logic item_last;  // latched item carries the end-of-set marker
        logic out_free;   // output register can take a result this cycle
        logic out_final;  // the entry being output is the last stored one
    } sts_t;

endpackage

### src/isi_datapath.sv
// Datapath of the insertion sorter: ordered store, position counters, output register.
`timescale 1ns / 1ps

module isi_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  isi_pkg::item_t  item,
    input  isi_pkg::cmd_t   cmd,
    output isi_pkg::sts_t   sts,
    output logic            result_valid,
    input  logic            result_stall,
    output isi_pkg::result_t result
);

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    // Ordered store, one write and one registered read per cycle
    logic [isi_pkg::DATA_W-1:0] store_mem [MAX_ITEMS];
    logic [isi_pkg::DATA_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]          rd_addr_reg;
    logic [ADDR_W-1:0]          rd_addr_next;

    logic signed [isi_pkg::DATA_W-1:0] value_reg;
    logic                              last_reg;
    logic [ADDR_W-1:0]                 pos_reg;
    logic [CNT_W-1:0]                  fill_reg;
    logic                              ovf_reg;
    logic [ADDR_W-1:0]                 idx_reg;

    logic                              out_valid_reg;
    isi_pkg::result_t                  out_reg;

    // Choose the next read address
    always_comb
    begin
        rd_addr_next = rd_addr_reg;
        priority if (cmd.load_in)
        begin
            rd_addr_next = ADDR_W'(fill_reg - CNT_W'(1));
        end
        else if (cmd.shift)
        begin
            rd_addr_next = pos_reg - ADDR_W'(2);
        end
        else if (cmd.start_out)
        begin
            rd_addr_next = '0;
        end
        else if (cmd.load_out)
        begin
            rd_addr_next = idx_reg + ADDR_W'(1);
        end
    end

    // Write and read the store
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            store_mem[pos_reg] <= rdata_reg;
        end
        else if (cmd.place)
        begin
            store_mem[pos_reg] <= value_reg;
        end
        rdata_reg <= store_mem[rd_addr_next];
    end

    // Hold the latched item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            value_reg <= item.value;
            last_reg  <= item.last;
        end
    end

    // Track fill count, position, drop flag, output index and read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            pos_reg     <= '0;
            idx_reg     <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            rd_addr_reg <= rd_addr_next;
            if (cmd.load_in)
            begin
                pos_reg <= ADDR_W'(fill_reg);
            end
            else if (cmd.shift)
            begin
                pos_reg <= pos_reg - ADDR_W'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.place)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.start_out)
            begin
                idx_reg <= '0;
            end
            else if (cmd.load_out)
            begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
            if (cmd.clear)
            begin
                fill_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    // Output register: load a result or drop it once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.sorted_value <= rdata_reg;
            out_reg.last_out     <= sts.out_final;
            out_reg.dropped      <= ovf_reg;
        end
    end

    // Report status
    always_comb
    begin
        sts.full      = (fill_reg == CNT_W'(MAX_ITEMS));
        sts.fill_zero = (fill_reg == '0);
        sts.greater   = ($signed(rdata_reg) > value_reg);
        sts.pos_one   = (pos_reg == ADDR_W'(1));
        sts.item_last = last_reg;
        sts.out_free  = !out_valid_reg || !result_stall;
        sts.out_final = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### src/isi_ctrl.sv
// Controller of the insertion sorter: sequences insertion and the output run.
`timescale 1ns / 1ps

module isi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  isi_pkg::sts_t sts,
    output isi_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE,
        ST_OUT_START,
        ST_OUT_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decide commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                priority if (sts.full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = sts.item_last ? ST_OUT_START : ST_IDLE;
                end
                else if (sts.fill_zero || !sts.greater)
                begin
                    cmd.place  = 1'b1;
                    state_next = sts.item_last ? ST_OUT_START : ST_IDLE;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = sts.pos_one ? ST_PLACE : ST_INSERT;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = sts.item_last ? ST_OUT_START : ST_IDLE;
            end
            ST_OUT_START:
            begin
                cmd.start_out = 1'b1;
                state_next    = ST_OUT_RUN;
            end
            ST_OUT_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.out_final)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);

endmodule

### src/insertion_sort_integers.sv
// Insertion sorter: a set of signed integers in, the set in ascending order out.
// Inserting an item moves each stored entry greater than it up one place; the shifts
// run through the single write port of the ordered store. After a marked item is
// inserted, a set-up step, then one result per cycle while the output is not stalled.
// Reset clears the fill count, the drop flag and the valid of the output register;
// the store contents are undefined and never read before they are written.
`timescale 1ns / 1ps

module insertion_sort_integers #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  isi_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output isi_pkg::result_t result
);

    isi_pkg::cmd_t cmd;
    isi_pkg::sts_t sts;

    // Sequence insertion and output
    isi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Store, counters and output register
    isi_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### tb/sv/isi_sort_checker.sv
// Checker for the integer insertion sorter: predicts each sorted run and compares results.
`timescale 1ns / 1ps

module isi_sort_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  isi_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  isi_pkg::result_t result,
    output int               mismatches,
    output int               pending,
    output int               results_checked,
    output int               dropped_runs
);

    // Predicted contents of the ordered store for the current set
    logic signed [isi_pkg::DATA_W-1:0] held [0:MAX_ITEMS-1];
    int                                held_n;
    bit                                held_ovf;

    // Sorted results still owed by the block, oldest first
    isi_pkg::result_t                  sorted_q [$];

    initial
    begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
        dropped_runs    = 0;
        held_n          = 0;
        held_ovf        = 1'b0;
    end

    // Place one value after every held value not greater than it, or record a drop when full
    task automatic insert_value(input logic signed [isi_pkg::DATA_W-1:0] v);
        int pos;
        if (held_n >= MAX_ITEMS)
        begin
            held_ovf = 1'b1;
            return;
        end
        pos = held_n;
        while (pos > 0 && held[pos-1] > v)
        begin
            held[pos] = held[pos-1];
            pos--;
        end
        held[pos] = v;
        held_n++;
    endtask

    // Queue the whole held set as a sorted run and empty the store
    task automatic release_run();
        isi_pkg::result_t r;
        for (int k = 0; k < held_n; k++)
        begin
            r.sorted_value = held[k];
            r.last_out     = (k == held_n - 1);
            r.dropped      = held_ovf;
            sorted_q.push_back(r);
        end
        if (held_ovf)
            dropped_runs++;
        held_n   = 0;
        held_ovf = 1'b0;
    endtask

    always @(posedge clk)
    begin : watch
        isi_pkg::result_t want;
        if (rst_n)
        begin
            // Compare each result transfer with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (sorted_q.size() == 0)
                begin
                    $display("%0t: unexpected result: actual value %0d last %0b dropped %0b",
                             $time, result.sorted_value, result.last_out, result.dropped);
                    mismatches++;
                end
                else
                begin
                    want = sorted_q.pop_front();
                    results_checked++;
                    if (result.sorted_value !== want.sorted_value)
                    begin
                        $display("%0t: sorted_value mismatch: expected %0d actual %0d",
                                 $time, want.sorted_value, result.sorted_value);
                        mismatches++;
                    end
                    if (result.last_out !== want.last_out)
                    begin
                        $display("%0t: last_out mismatch: expected %0b actual %0b",
                                 $time, want.last_out, result.last_out);
                        mismatches++;
                    end
                    if (result.dropped !== want.dropped)
                    begin
                        $display("%0t: dropped mismatch: expected %0b actual %0b",
                                 $time, want.dropped, result.dropped);
                        mismatches++;
                    end
                end
            end
            // Advance the prediction on each item transfer
            if (item_valid && !item_stall)
            begin
                insert_value(item.value);
                if (item.last)
                    release_run();
            end
            pending = sorted_q.size();
        end
    end

endmodule

### tb/sv/tb_insertion_sort_integers.sv
// Top of the insertion sorter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_insertion_sort_integers;

    localparam int MAX_ITEMS   = 64;
    localparam int ITEM_TARGET = 470;
    localparam int CALM_TAIL   = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;

    // Value patterns for set contents
    typedef enum int {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_EXTREME,
        PAT_MIXED
    } pattern_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    isi_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    isi_pkg::result_t result;

    int      mismatches;
    int      pending;
    int      results_checked;
    int      dropped_runs;

    int      items_sent;
    int      sets_sent;
    bit      calm;
    bit      hold_req;
    bit      hold_done;

    insertion_sort_integers #(
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    isi_sort_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .dropped_runs    (dropped_runs)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Draw one element according to a value pattern
    function automatic logic signed [isi_pkg::DATA_W-1:0] pick_value(input pattern_t pat);
        int m;
        m = (pat == PAT_MIXED) ? $urandom_range(0, 2) : int'(pat);
        case (m)
            PAT_NARROW:  return int'($urandom_range(0, 8)) - 4;
            PAT_EXTREME:
                case ($urandom_range(0, 5))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh8000_0001;
                    2:       return 32'sh7fff_ffff;
                    3:       return 32'sh7fff_fffe;
                    4:       return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            default:     return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the transfer completes
    task automatic send_item(input logic signed [isi_pkg::DATA_W-1:0] v, input logic is_last);
        @(negedge clk);
        item_valid = 1'b1;
        item.value = v;
        item.last  = is_last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (is_last)
            sets_sent++;
    endtask

    // Drop valid for a burst of cycles, with junk on the payload
    task automatic sender_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            item.value = $urandom;
            item.last  = 1'($urandom_range(0, 1));
        end
    endtask

    // Send a set of n elements, the final one marked, with random gaps
    task automatic send_set(input int n, input pattern_t pat);
        for (int i = 0; i < n; i++)
        begin
            send_item(pick_value(pat), i == n - 1);
            if (!calm && $urandom_range(0, 5) == 0)
                sender_gap($urandom_range(1, 8));
        end
    endtask

    // Result side: random stall bursts and one long hold-off
    initial
    begin
        result_stall = 1'b0;
        hold_done    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall = 1'b0;
                hold_done    = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_stall = 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                result_stall = 1'b0;
        end
    end

    // Watchdog: end the run after too long without any transfer
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int set_idx;
        int n;
        item_valid = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        items_sent = 0;
        sets_sent  = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-element sets at both extremes
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 1'b1);
        // Directed: duplicates, signed ordering and both extremes in one set
        send_item(32'sd7, 1'b0);
        send_item(-32'sd7, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd1, 1'b1);
        // Directed: descending input, each element shifts the whole store
        for (int i = 5; i >= 1; i--)
            send_item(i, i == 1);
        // Directed: ascending input, no shifts
        send_item(-32'sd2, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd0, 1'b1);

        // Pause until every directed result has come back
        sender_gap(1);
        wait (pending == 0);

        // Random sets: a full store, an overflow, a random set, a long output hold, then a mix
        set_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - CALM_TAIL)
                calm = 1'b1;
            if (set_idx == 0)
                send_set(MAX_ITEMS, PAT_RANDOM);
            else if (set_idx == 1)
                send_set(MAX_ITEMS + 1 + $urandom_range(0, 3), PAT_MIXED);
            else if (set_idx == 3)
            begin
                hold_req = 1'b1;
                send_set(20, PAT_MIXED);
            end
            else
            begin
                case ($urandom_range(0, 29))
                    0:       n = MAX_ITEMS;
                    1:       n = MAX_ITEMS + $urandom_range(1, 4);
                    default: n = $urandom_range(1, 12);
                endcase
                send_set(n, pattern_t'($urandom_range(0, 3)));
            end
            set_idx++;
            // Now and then let the sorter drain completely
            if (!calm && $urandom_range(0, 14) == 0)
            begin
                sender_gap(1);
                wait (pending == 0);
            end
        end
        sender_gap(1);

        // Drain, then allow for any stray results
        wait (pending == 0);
        repeat (MAX_ITEMS + 16) @(posedge clk);

        $display("Sent %0d items in %0d sets; checked %0d sorted results.",
                 items_sent, sets_sent, results_checked);
        $display("%0d runs reported dropped elements; %0d mismatches.",
                 dropped_runs, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
src/isi_pkg.sv
src/isi_datapath.sv
src/isi_ctrl.sv
src/insertion_sort_integers.sv
tb/sv/isi_sort_checker.sv
tb/sv/tb_insertion_sort_integers.sv
